/* hw/rtl/hit_pkg.sv */
// Shared types and constants for the histogram isodata threshold block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package hit_pkg;

   localparam int NUM_BINS  = 256;
   localparam int BIN_AW    = 8;
   localparam int PIX_W     = 8;
   localparam int CNT_W     = 21;
   localparam int TOT_CNT_W = CNT_W + BIN_AW;
   localparam int SUM_W     = TOT_CNT_W + PIX_W;
   localparam int PROD_W    = CNT_W + PIX_W;

   localparam logic [CNT_W-1:0] BIN_MAX = {CNT_W{1'b1}};
   localparam logic [PIX_W-1:0] THR_MAX = {PIX_W{1'b1}};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // capture a request and read its bin
      logic upd;        // write back the incremented bin
      logic scan_init;  // reset the scan index and the lower sums
      logic fetch;      // read the bin at the scan index
      logic div_start;  // launch both mean dividers
      logic lo_add;     // fold the current bin into the lower sums
      logic t_inc;      // advance the scan index
      logic set_found;  // load the result with the scan index
      logic set_none;   // load the no-convergence result
      logic clear;      // empty the histogram after the response
   } hit_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;       // captured request ends the frame
      logic started;    // scan has reached the lowest occupied bin
      logic div_done;   // dividers finish in this cycle
      logic match;      // stop condition holds at the scan index
      logic t_last;     // scan index is the top bin
   } hit_sts_type;

endpackage

/* hw/rtl/hit_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on hit_pkg for field widths.
`timescale 1ns / 1ps

interface hit_req_if import hit_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             last_pixel;

   modport source (output valid, pixel, last_pixel, input ready);
   modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

interface hit_rsp_if import hit_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] threshold;
   logic             no_convergence;

   modport source (output valid, threshold, no_convergence, input ready);
   modport sink   (input valid, threshold, no_convergence, output ready);
endinterface

/* hw/rtl/hit_div.sv */
// Restoring divider with an 8-bit quotient, one quotient bit per cycle.
// The caller guarantees num < 256 * den; a zero divisor gives zero.
`timescale 1ns / 1ps

module hit_div import hit_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_W-1:0]     num,
   input  logic [TOT_CNT_W-1:0] den,
   output logic [PIX_W-1:0]     quot,
   output logic                 done
);

   logic                 busy_ff, busy_in;
   logic [2:0]           k_ff, k_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [TOT_CNT_W-1:0] den_ff, den_in;
   logic                 dz_ff, dz_in;
   logic [PIX_W-1:0]     q_ff, q_in;
   logic [SUM_W-1:0]     trial;

   // One trial subtraction of the shifted divisor per cycle.
   always_comb begin
      trial   = SUM_W'(den_ff) << k_ff;
      busy_in = busy_ff;
      k_in    = k_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dz_in   = dz_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = 3'd7;
         rem_in  = num;
         den_in  = den;
         dz_in   = (den == '0);
         q_in    = '0;
      end else if (busy_ff) begin
         if (!dz_ff && rem_ff >= trial) begin
            rem_in       = rem_ff - trial;
            q_in[k_ff]   = 1'b1;
         end
         k_in = k_ff - 3'd1;
         if (k_ff == 3'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      k_ff   <= k_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      dz_ff  <= dz_in;
      q_ff   <= q_in;
   end

   assign done = busy_ff && (k_ff == 3'd0);
   assign quot = q_ff;

endmodule

/* hw/rtl/hit_dp.sv */
// Datapath: histogram memory with valid bits, frame totals, scan sums,
// mean dividers and the result register. Depends on hit_pkg and hit_div.
`timescale 1ns / 1ps

module hit_dp import hit_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  hit_cmd_type      cmd,
   output hit_sts_type      sts,
   input  logic [PIX_W-1:0] pixel,
   input  logic             last_pixel,
   output logic [PIX_W-1:0] threshold,
   output logic             no_convergence
);

   logic [CNT_W-1:0]     mem [NUM_BINS];
   logic [NUM_BINS-1:0]  vld_ff;
   logic [CNT_W-1:0]     rd_ff;
   logic                 rdv_ff;
   logic [BIN_AW-1:0]    pix_ff;
   logic                 last_ff;
   logic [BIN_AW-1:0]    t_ff;
   logic                 started_ff;
   logic [TOT_CNT_W-1:0] all_cnt_ff, lo_cnt_ff;
   logic [SUM_W-1:0]     all_sum_ff, lo_sum_ff;
   logic [PIX_W-1:0]     thr_ff;
   logic                 nc_ff;

   logic [BIN_AW-1:0]    rd_addr;
   logic [CNT_W-1:0]     cnt;
   logic                 bump;
   logic [PROD_W-1:0]    prod;
   logic [PIX_W-1:0]     q_lo, q_hi;
   logic                 done_lo, done_hi;
   logic [PIX_W:0]       q_sum;
   logic [PIX_W:0]       t_next;

   // A bin that was not written since the last clear reads as zero.
   assign cnt     = rdv_ff ? rd_ff : '0;
   assign bump    = (cnt != BIN_MAX);
   assign rd_addr = cmd.accept ? pixel : t_ff;
   assign prod    = PROD_W'(t_ff) * PROD_W'(cnt);

   // Histogram memory: one registered read port, one write port.
   always_ff @(posedge clock) begin
      if (cmd.accept || cmd.fetch) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.upd && bump) begin
         mem[pix_ff] <= cnt + CNT_W'(1);
      end
   end

   // Valid bits stand in for clearing the memory.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         vld_ff <= '0;
      end else if (cmd.upd) begin
         vld_ff[pix_ff] <= 1'b1;
      end
      if (cmd.accept || cmd.fetch) begin
         rdv_ff <= vld_ff[rd_addr];
      end
   end

   // Captured request and frame totals.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff  <= pixel;
         last_ff <= last_pixel;
      end
      if (reset || cmd.clear) begin
         all_cnt_ff <= '0;
         all_sum_ff <= '0;
      end else if (cmd.upd && bump) begin
         all_cnt_ff <= all_cnt_ff + TOT_CNT_W'(1);
         all_sum_ff <= all_sum_ff + SUM_W'(pix_ff);
      end
   end

   // Scan index and the sums over the bins below it.
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         t_ff       <= '0;
         started_ff <= 1'b0;
         lo_cnt_ff  <= '0;
         lo_sum_ff  <= '0;
      end else begin
         if (cmd.div_start) begin
            started_ff <= 1'b1;
         end
         if (cmd.lo_add) begin
            lo_cnt_ff <= lo_cnt_ff + TOT_CNT_W'(cnt);
            lo_sum_ff <= lo_sum_ff + SUM_W'(prod);
         end
         if (cmd.t_inc) begin
            t_ff <= t_ff + BIN_AW'(1);
         end
      end
   end

   hit_div u_div_lo (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (lo_sum_ff),
      .den   (lo_cnt_ff),
      .quot  (q_lo),
      .done  (done_lo)
   );

   hit_div u_div_hi (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (all_sum_ff - lo_sum_ff),
      .den   (all_cnt_ff - lo_cnt_ff),
      .quot  (q_hi),
      .done  (done_hi)
   );

   // Stop condition: floor of the mean sum over two equals t + 1.
   assign q_sum  = {1'b0, q_lo} + {1'b0, q_hi};
   assign t_next = {1'b0, t_ff} + (PIX_W+1)'(1);

   always_ff @(posedge clock) begin
      if (cmd.set_found) begin
         thr_ff <= t_ff;
         nc_ff  <= 1'b0;
      end else if (cmd.set_none) begin
         thr_ff <= THR_MAX;
         nc_ff  <= 1'b1;
      end
   end

   assign threshold      = thr_ff;
   assign no_convergence = nc_ff;

   always_comb begin
      sts.last     = last_ff;
      sts.started  = started_ff || (cnt != '0) || (t_ff == BIN_AW'(NUM_BINS - 1));
      sts.div_done = done_lo && done_hi;
      sts.match    = ({1'b0, q_sum[PIX_W:1]} == t_next);
      sts.t_last   = (t_ff == BIN_AW'(NUM_BINS - 1));
   end

endmodule

/* hw/rtl/hit_ctrl.sv */
// Controller: sequences bin updates, the threshold scan and the response.
// Depends on hit_pkg; drives the datapath through hit_cmd_type.
`timescale 1ns / 1ps

module hit_ctrl import hit_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  hit_sts_type sts,
   output hit_cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_UPD   = 7'b0000010,
      S_FETCH = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_CHECK = 7'b0100000,
      S_OUT   = 7'b1000000
   } hit_state_type;

   hit_state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (sts.last) begin
               cmd.scan_init = 1'b1;
               state_in      = S_FETCH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            if (sts.started) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.lo_add = 1'b1;
               cmd.t_inc  = 1'b1;
               state_in   = S_FETCH;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.match) begin
               cmd.set_found = 1'b1;
               state_in      = S_OUT;
            end else if (sts.t_last) begin
               cmd.set_none = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.lo_add = 1'b1;
               cmd.t_inc  = 1'b1;
               state_in   = S_FETCH;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/histogram_isodata_threshold.sv */
// Histogram isodata threshold. Each pixel is a bin read, then a write back;
// no new pixel is taken until the write back is done. On the last pixel the
// scan walks the bins through one memory read port: fetch and evaluate per bin
// below the lowest occupied bin, then fetch, evaluate, 8 divider steps, check.
// Synchronous reset empties the histogram at once through per-bin valid bits.
`timescale 1ns / 1ps

module histogram_isodata_threshold import hit_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hit_req_if.sink    req_ch,
   hit_rsp_if.source  rsp_ch
);

   hit_cmd_type cmd;
   hit_sts_type sts;

   hit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hit_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .pixel          (req_ch.pixel),
      .last_pixel     (req_ch.last_pixel),
      .threshold      (rsp_ch.threshold),
      .no_convergence (rsp_ch.no_convergence)
   );

endmodule

/* hw/rtl/hit_checker.sv */
// Port-level checks for the histogram isodata threshold block.
// Depends on hit_pkg; bound to the top level below.
`timescale 1ns / 1ps

module hit_checker import hit_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] threshold,
   input logic             no_convergence
);

   // A pending response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(threshold) && $stable(no_convergence))
      else $error("response payload changed while stalled");

   // The no-convergence flag always comes with the top threshold.
   a_nc_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && no_convergence |-> threshold == THR_MAX)
      else $error("no-convergence response without top threshold");

   // Requests are not taken while a response is pending.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted during a pending response");

   // Every accepted request needs a bin write before the next one.
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back request acceptance");

endmodule

bind histogram_isodata_threshold hit_checker u_hit_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .threshold      (rsp_ch.threshold),
   .no_convergence (rsp_ch.no_convergence)
);

/* tb/histogram_isodata_threshold_tb.sv */
// Self-checking testbench for the histogram isodata threshold block.
// Depends on hit_pkg and the channel interfaces in hit_if.sv.
`timescale 1ns / 1ps

module histogram_isodata_threshold_tb;
   import hit_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last_pixel;
      logic             known;      // expected result typed in below
      logic [PIX_W-1:0] thr;
      logic             nc;
   } stim_row_type;

   typedef struct packed {
      logic [PIX_W-1:0] thr;
      logic             nc;
   } thr_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hit_req_if req_ch ();
   hit_rsp_if rsp_ch ();

   histogram_isodata_threshold DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // Predictor state: its own copy of the histogram.
   logic [CNT_W-1:0] bins_model [NUM_BINS];
   thr_result_type   pending_thr [$];
   thr_result_type   typed_thr [$];
   bit               typed_known [$];
   int               errors     = 0;
   int               results    = 0;
   int               frames     = 0;
   int               nc_seen    = 0;
   int               send_idle  = 0;
   int               recv_stall = 0;

   // Isodata scan over the predicted histogram.
   function automatic thr_result_type isodata_scan();
      longint unsigned all_cnt, all_sum, lo_cnt, lo_sum, lower, upper, mid;
      int              start;
      thr_result_type  r;
      all_cnt = 0; all_sum = 0; lo_cnt = 0; lo_sum = 0;
      r.thr = THR_MAX;
      r.nc  = 1'b1;
      for (int t = 0; t < NUM_BINS; t++) begin
         all_cnt += bins_model[t];
         all_sum += longint'(t) * bins_model[t];
      end
      start = 0;
      while (start < NUM_BINS - 1 && bins_model[start] == 0) start++;
      for (int t = 0; t < start; t++) begin
         lo_cnt += bins_model[t];
         lo_sum += longint'(t) * bins_model[t];
      end
      for (int t = start; t < NUM_BINS; t++) begin
         lower = (lo_cnt == 0) ? 0 : lo_sum / lo_cnt;
         upper = (all_cnt == lo_cnt) ? 0 : (all_sum - lo_sum) / (all_cnt - lo_cnt);
         mid = (lower + upper) >> 1;
         if (mid == longint'(t) + 1) begin
            r.thr = t[PIX_W-1:0];
            r.nc  = 1'b0;
            return r;
         end
         lo_cnt += bins_model[t];
         lo_sum += longint'(t) * bins_model[t];
      end
      return r;
   endfunction

   // Count one accepted request into the model; a last pixel yields a result.
   task automatic predict_pixel(input logic [PIX_W-1:0] p, input logic last);
      thr_result_type r;
      if (bins_model[p] != BIN_MAX) bins_model[p] = bins_model[p] + 1'b1;
      if (last) begin
         r = isodata_scan();
         pending_thr.push_back(r);
         frames++;
         if (r.nc) nc_seen++;
         for (int i = 0; i < NUM_BINS; i++) bins_model[i] = '0;
      end
   endtask

   // Send one request: idle first as the phase asks, hold until accepted.
   // Valid stays high after acceptance so that requests can follow directly.
   task automatic send_pixel(input logic [PIX_W-1:0] p, input logic last);
      if (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
         while (send_idle != 0 && $urandom_range(99) < send_idle) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.pixel      <= p;
      req_ch.last_pixel <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_pixel(p, last);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic wait_drained();
      if (req_ch.valid) req_ch.valid <= 1'b0;
      while (pending_thr.size() != 0) @(negedge clock);
   endtask

   // Random frame of the given length on a gray band, mostly a narrow one.
   task automatic random_frame(input int len);
      int lo, span;
      lo   = $urandom_range(255);
      span = ($urandom_range(3) == 0) ? 256 : $urandom_range(1, 40);
      for (int i = 0; i < len; i++)
         send_pixel(8'((lo + $urandom_range(span - 1)) % 256), i == len - 1);
   endtask

   // Response side: random stall, check each accepted response in order.
   always @(negedge clock)
      rsp_ch.ready <= reset ? 1'b0 :
                      !(recv_stall != 0 && $urandom_range(99) < recv_stall);

   always @(posedge clock) begin
      thr_result_type want, got, typed;
      bit             known;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.thr = rsp_ch.threshold;
         got.nc  = rsp_ch.no_convergence;
         results++;
         if (pending_thr.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected response thr=%0d nc=%0b", got.thr, got.nc);
         end else begin
            want = pending_thr.pop_front();
            if (typed_thr.size() != 0) begin
               // Directed rows with a typed value are also checked against it.
               typed = typed_thr.pop_front();
               known = typed_known.pop_front();
               if (known && (got.thr !== typed.thr || got.nc !== typed.nc)) begin
                  errors++;
                  if (errors <= 10)
                     $display("Mismatch on directed row: expected thr=%0d nc=%0b, got thr=%0d nc=%0b",
                              typed.thr, typed.nc, got.thr, got.nc);
               end
            end
            if (got.thr !== want.thr || got.nc !== want.nc) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch: expected thr=%0d nc=%0b, got thr=%0d nc=%0b",
                           want.thr, want.nc, got.thr, got.nc);
            end
         end
      end
   end

   // Directed table; a one-pixel frame at v has mean v above, so stop needs
   // v/2 == v+1, which never holds: no convergence.
   stim_row_type directed [] = '{
      '{8'd0,   1'b1, 1'b1, 8'd255, 1'b1},
      '{8'd255, 1'b1, 1'b1, 8'd255, 1'b1},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
      '{8'd10,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd200, 1'b1, 1'b0, 8'd0,   1'b0},
      '{8'd85,  1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd170, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd254, 1'b1, 1'b0, 8'd0,   1'b0},
      '{8'd128, 1'b1, 1'b1, 8'd255, 1'b1},
      '{8'd127, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{8'd255, 1'b1, 1'b0, 8'd0,   1'b0}
   };

   initial begin
      int sent;
      thr_result_type typed_row;
      req_ch.valid      = 1'b0;
      req_ch.pixel      = '0;
      req_ch.last_pixel = 1'b0;
      rsp_ch.ready      = 1'b0;
      for (int i = 0; i < NUM_BINS; i++) bins_model[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows; every last row queues its typed value and whether it is known.
      foreach (directed[i]) begin
         if (directed[i].last_pixel) begin
            typed_row.thr = directed[i].thr;
            typed_row.nc  = directed[i].nc;
            typed_thr.push_back(typed_row);
            typed_known.push_back(directed[i].known);
         end
         send_pixel(directed[i].pixel, directed[i].last_pixel);
      end
      wait_drained();
      typed_thr.delete();
      typed_known.delete();

      // Random frames across the idling phases.
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 85; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 85; end
            default: begin send_idle = 7; recv_stall = 7; end
         endcase
         while (sent < (phase + 1) * 500) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            random_frame(len);
            sent += len;
         end
         // Hold off until every pending result is back.
         wait_drained();
      end

      wait_drained();
      repeat (3000) @(posedge clock);
      $display("Covered %0d frames (%0d without convergence), %0d responses checked.",
               frames, nc_seen, results);
      if (errors == 0 && pending_thr.size() == 0)
         $display("PASS histogram_isodata_threshold");
      else
         $display("FAIL histogram_isodata_threshold");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #200ms;
      $display("FAIL histogram_isodata_threshold");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/hit_pkg.sv
hw/rtl/hit_if.sv
hw/rtl/hit_div.sv
hw/rtl/hit_dp.sv
hw/rtl/hit_ctrl.sv
hw/rtl/histogram_isodata_threshold.sv
hw/rtl/hit_checker.sv
tb/histogram_isodata_threshold_tb.sv
